>>> sv/ptns_pkg.sv
`timescale 1ns / 1ps

package ptns_pkg;

    // Width of the value and prime_value fields on the ports.
    localparam int VALUE_W = 32;

    // Action codes. Code zero and the unused code three both run a plain test.
    localparam logic [1:0] ACT_NEXT = 2'd1;
    localparam logic [1:0] ACT_PREV = 2'd2;

    // Divisor schedule: 3, then the pairs d and d+2 starting at 5, stepping by 6.
    localparam int DIV_FIRST = 3;
    localparam int D_FIRST   = 5;
    localparam int D_PAIR    = 2;
    localparam int D_STRIDE  = 6;

    typedef struct packed {
        logic [1:0]         action;
        logic [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [VALUE_W-1:0] prime_value;
        logic               prime_flag;
        logic               overflow;
    } result_t;

    // What happens after a candidate turns out not to be prime.
    typedef enum logic [1:0] {
        MODE_SINGLE,
        MODE_NEXT,
        MODE_PREV
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV3,
        S_DIVA,
        S_DIVB,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_BY_3,
        DIV_BY_5,
        DIV_BY_D2,
        DIV_BY_D6
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     d_init;
        logic     d_step;
        logic     verdict_we;
        logic     verdict;
        logic     cand_step;
        logic     ovf_set;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  cand_lt2;
        logic  cand_lt4;
        logic  cand_even;
        logic  at_top;
        logic  div_done;
        logic  rem_zero;
        logic  d_gt_q;
    } status_t;

endpackage

>>> sv/ptns_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module ptns_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W);

    logic             active_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dsr_reg;

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         fits;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? diff[W-1:0] : trial[W-1:0];
        quo_next = {quo_reg[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            done_reg   <= 1'b0;
            cnt_reg    <= CNT_W'(W - 1);
        end
        else if (active_reg)
        begin
            cnt_reg    <= cnt_reg - 1'b1;
            active_reg <= (cnt_reg != '0);
            done_reg   <= (cnt_reg == '0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (active_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // A new division must never be launched on top of one in flight.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !active_reg)
        else $error("divider restarted while active");

    // The done pulse is a single cycle wide.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

>>> sv/ptns_dp.sv
`timescale 1ns / 1ps

// Datapath: candidate, trial divisor, verdict flags and the shared divider.
module ptns_dp #(
    parameter int W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ptns_pkg::request_t request,
    input  ptns_pkg::cmd_t     cmd,
    output ptns_pkg::status_t  status,
    output ptns_pkg::result_t  result
);

    localparam int VW = ptns_pkg::VALUE_W;

    ptns_pkg::mode_t mode_reg;
    ptns_pkg::mode_t mode_next;
    logic [W-1:0]    cand_reg;
    logic [W-1:0]    cand_next;
    logic [W-1:0]    d_reg;
    logic            pr_reg;
    logic            ovf_reg;

    logic [W-1:0]  v_in;
    logic [VW-1:0] prime_out;
    logic [W-1:0]  div_divisor;
    logic          div_done;
    logic [W-1:0]  div_quo;
    logic [W-1:0]  div_rem;

    // Operand reduced or extended to the internal width, and back again.
    if (W > VW)
    begin : g_wide
        assign v_in      = {{(W-VW){1'b0}}, request.value};
        assign prime_out = cand_reg[VW-1:0];
    end
    else if (W == VW)
    begin : g_same
        assign v_in      = request.value;
        assign prime_out = cand_reg;
    end
    else
    begin : g_narrow
        assign v_in      = request.value[W-1:0];
        assign prime_out = {{(VW-W){1'b0}}, cand_reg};
    end

    // Search mode and first candidate; searches from 0 and 2, and the
    // predecessor of 1, only test the operand itself.
    always_comb
    begin
        mode_next = ptns_pkg::MODE_SINGLE;
        cand_next = v_in;
        case (request.action)
            ptns_pkg::ACT_NEXT:
            begin
                if (!(v_in inside {W'(0), W'(2)}))
                begin
                    mode_next = ptns_pkg::MODE_NEXT;
                    if (!v_in[0])
                    begin
                        cand_next = v_in + W'(1);
                    end
                end
            end
            ptns_pkg::ACT_PREV:
            begin
                if (!(v_in inside {W'(0), W'(1), W'(2)}))
                begin
                    mode_next = ptns_pkg::MODE_PREV;
                    if (!v_in[0])
                    begin
                        cand_next = v_in - W'(1);
                    end
                end
            end
            default:
            begin
                mode_next = ptns_pkg::MODE_SINGLE;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.div_sel)
            ptns_pkg::DIV_BY_3:  div_divisor = W'(ptns_pkg::DIV_FIRST);
            ptns_pkg::DIV_BY_5:  div_divisor = W'(ptns_pkg::D_FIRST);
            ptns_pkg::DIV_BY_D2: div_divisor = d_reg + W'(ptns_pkg::D_PAIR);
            ptns_pkg::DIV_BY_D6: div_divisor = d_reg + W'(ptns_pkg::D_STRIDE);
            default:             div_divisor = W'(ptns_pkg::DIV_FIRST);
        endcase
    end

    ptns_div #(
        .W(W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (cand_reg),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ptns_pkg::MODE_SINGLE;
        end
        else if (cmd.load)
        begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cand_reg <= cand_next;
            ovf_reg  <= 1'b0;
            pr_reg   <= 1'b0;
        end
        else if (cmd.ovf_set)
        begin
            cand_reg <= '0;
            ovf_reg  <= 1'b1;
            pr_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.cand_step)
            begin
                if (mode_reg == ptns_pkg::MODE_PREV)
                begin
                    cand_reg <= cand_reg - W'(ptns_pkg::D_PAIR);
                end
                else
                begin
                    cand_reg <= cand_reg + W'(ptns_pkg::D_PAIR);
                end
            end
            if (cmd.verdict_we)
            begin
                pr_reg <= cmd.verdict;
            end
        end

        if (cmd.d_init)
        begin
            d_reg <= W'(ptns_pkg::D_FIRST);
        end
        else if (cmd.d_step)
        begin
            d_reg <= d_reg + W'(ptns_pkg::D_STRIDE);
        end
    end

    always_comb
    begin
        status.mode      = mode_reg;
        status.cand_lt2  = (cand_reg[W-1:1] == '0);
        status.cand_lt4  = (cand_reg[W-1:2] == '0);
        status.cand_even = !cand_reg[0];
        status.at_top    = &cand_reg[W-1:1];
        status.div_done  = div_done;
        status.rem_zero  = (div_rem == '0);
        status.d_gt_q    = (d_reg > div_quo);
    end

    assign result.prime_value = prime_out;
    assign result.prime_flag  = pr_reg;
    assign result.overflow    = ovf_reg;

endmodule

>>> sv/ptns_ctrl.sv
`timescale 1ns / 1ps

// Sequencer for the trial division and the neighbour search.
module ptns_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ptns_pkg::status_t status,
    output ptns_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);

    ptns_pkg::state_t state_reg;
    ptns_pkg::state_t state_next;

    logic hit;
    logic hit_val;
    logic finish;
    logic ovf_now;

    // A verdict on the current candidate, and what it leads to. Two and three
    // are prime, so the small-value test comes before the even test.
    always_comb
    begin
        hit     = 1'b0;
        hit_val = 1'b0;
        case (state_reg)
            ptns_pkg::S_CHECK:
            begin
                if (status.cand_lt2)
                begin
                    hit = 1'b1;
                end
                else if (status.cand_lt4)
                begin
                    hit     = 1'b1;
                    hit_val = 1'b1;
                end
                else if (status.cand_even)
                begin
                    hit = 1'b1;
                end
            end
            ptns_pkg::S_DIV3, ptns_pkg::S_DIVB:
            begin
                hit = status.div_done && status.rem_zero;
            end
            ptns_pkg::S_DIVA:
            begin
                if (status.div_done && status.d_gt_q)
                begin
                    hit     = 1'b1;
                    hit_val = 1'b1;
                end
                else if (status.div_done && status.rem_zero)
                begin
                    hit = 1'b1;
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
        ovf_now = hit && !hit_val && (status.mode == ptns_pkg::MODE_NEXT) && status.at_top;
        finish  = hit && (hit_val || (status.mode == ptns_pkg::MODE_SINGLE) || ovf_now);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptns_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ptns_pkg::S_CHECK;
                end
            end
            ptns_pkg::S_CHECK:
            begin
                if (hit)
                begin
                    state_next = finish ? ptns_pkg::S_DONE : ptns_pkg::S_CHECK;
                end
                else
                begin
                    state_next = ptns_pkg::S_DIV3;
                end
            end
            ptns_pkg::S_DIV3:
            begin
                if (hit)
                begin
                    state_next = finish ? ptns_pkg::S_DONE : ptns_pkg::S_CHECK;
                end
                else if (status.div_done)
                begin
                    state_next = ptns_pkg::S_DIVA;
                end
            end
            ptns_pkg::S_DIVA:
            begin
                if (hit)
                begin
                    state_next = finish ? ptns_pkg::S_DONE : ptns_pkg::S_CHECK;
                end
                else if (status.div_done)
                begin
                    state_next = ptns_pkg::S_DIVB;
                end
            end
            ptns_pkg::S_DIVB:
            begin
                if (hit)
                begin
                    state_next = finish ? ptns_pkg::S_DONE : ptns_pkg::S_CHECK;
                end
                else if (status.div_done)
                begin
                    state_next = ptns_pkg::S_DIVA;
                end
            end
            ptns_pkg::S_DONE:
            begin
                state_next = ptns_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ptns_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.div_sel    = ptns_pkg::DIV_BY_3;
        cmd.verdict_we = hit;
        cmd.verdict    = hit_val;
        cmd.ovf_set    = ovf_now;
        cmd.cand_step  = hit && !finish;
        case (state_reg)
            ptns_pkg::S_IDLE:
            begin
                cmd.load = start;
            end
            ptns_pkg::S_CHECK:
            begin
                if (!hit)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ptns_pkg::DIV_BY_3;
                end
            end
            ptns_pkg::S_DIV3:
            begin
                if (!hit && status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ptns_pkg::DIV_BY_5;
                    cmd.d_init    = 1'b1;
                end
            end
            ptns_pkg::S_DIVA:
            begin
                if (!hit && status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ptns_pkg::DIV_BY_D2;
                end
            end
            ptns_pkg::S_DIVB:
            begin
                if (!hit && status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ptns_pkg::DIV_BY_D6;
                    cmd.d_step    = 1'b1;
                end
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptns_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ptns_pkg::S_IDLE);
    assign done = (state_reg == ptns_pkg::S_DONE);

    // Overflow is only possible while searching upward.
    a_ovf_mode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ovf_set |-> (status.mode == ptns_pkg::MODE_NEXT))
        else $error("overflow raised outside the successor search");

    // A divide-wait state is left only after the divider reports completion.
    a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ptns_pkg::S_DIVA || state_reg == ptns_pkg::S_DIVB)
            && !status.div_done) |=> $stable(state_reg))
        else $error("left a divide state before the divider finished");

endmodule

>>> sv/prime_test_and_neighbour_search.sv
`timescale 1ns / 1ps

// Channel  | Ports                          | Handshake
// ---------+--------------------------------+-----------------------------------------
// request  | request.action, request.value  | taken on a clock edge with start=1, busy=0
// result   | result.prime_value, .prime_flag, | shown for exactly one cycle with done=1
//          | result.overflow                |
//
// One request is worked on at a time; busy is high from acceptance through the done cycle.
// Each test of an odd candidate runs divisions on the shared restoring divider, by 3 and then by
// the pairs d and d+2, until one of them divides it or d exceeds the quotient; a search
// repeats that for every odd candidate it visits.
// Reset clears the sequencer asynchronously; the first clock edge after release can take
// a request. The receiver cannot stall: a result is presented once and is not held.
module prime_test_and_neighbour_search #(
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ptns_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output ptns_pkg::result_t  result
);

    // Command and status bundles between the sequencer and the datapath.
    ptns_pkg::cmd_t    cmd;
    ptns_pkg::status_t status;

    // The sequencer walks through the divisor schedule 3, 5, 7, 11, 13, ...
    // and decides after each division whether the candidate is settled.
    ptns_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath holds the candidate, the current trial divisor, the
    // verdict flags and the divider itself; its registers feed the result
    // ports directly.
    ptns_dp #(
        .W(VALUE_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

    // The block only becomes busy because a request was taken.
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // An overflowed search reports zero and no prime.
    a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> (!result.prime_flag && result.prime_value == '0))
        else $error("overflow result carries a value or a prime flag");

endmodule

>>> tb/prime_test_and_neighbour_search_test.sv
`timescale 1ns / 1ps

// Checks the prime test and neighbour search block against a predictor that
// runs inside this module. Every request is predicted when the block accepts
// it, and every strobed result is compared field by field with the oldest
// prediction still waiting.
module prime_test_and_neighbour_search_test;

    localparam int VALUE_BITS = 32;

    // Action codes that the package does not name. The spare code runs a test.
    localparam logic [1:0] ACT_TEST  = 2'd0;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // A generous cost of one division on the shared divider, in cycles.
    localparam int DIV_CYCLES  = VALUE_BITS + 8;
    localparam int MAX_REPORTS = 10;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    ptns_pkg::request_t request = '0;
    logic               busy;
    logic               done;
    ptns_pkg::result_t  result;

    // Predicted results, oldest first.
    ptns_pkg::result_t expected_results[$];
    int                mismatch_count = 0;
    // Divisions the block needs for the request being predicted; it sizes the
    // watchdog limit.
    longint unsigned   division_tally = 0;
    longint unsigned   cycle_count    = 0;
    longint unsigned   cycle_limit    = 20000;

    prime_test_and_neighbour_search #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Trial division: 2 and 3 first, then the pairs d and d+2 from 5 in steps
    // of 6 while d does not exceed n / d. The tally follows the divider work.
    function automatic bit passes_trial_division(input longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 1'b0;
        if (n < 4)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        division_tally += 1;
        if (n % ptns_pkg::DIV_FIRST == 0)
            return 1'b0;
        for (d = ptns_pkg::D_FIRST; d <= n / d; d += ptns_pkg::D_STRIDE)
        begin
            division_tally += 2;
            if (n % d == 0 || n % (d + ptns_pkg::D_PAIR) == 0)
                return 1'b0;
        end
        division_tally += 1;
        return 1'b1;
    endfunction

    // Works out the result of one request. Searches from 0 and from 2 return
    // the operand itself, as does the predecessor search from 1. A successor
    // search that runs off the top of the value range reports overflow.
    function automatic ptns_pkg::result_t search_prime(input ptns_pkg::request_t req);
        longint unsigned   mask;
        longint unsigned   v;
        longint unsigned   r;
        bit                ovf;
        ptns_pkg::result_t res;
        mask = (64'd1 << VALUE_BITS) - 1;
        v    = req.value & mask;
        r    = v;
        ovf  = 1'b0;
        if (req.action == ptns_pkg::ACT_NEXT)
        begin
            if (v != 0 && v != 2)
            begin
                if (v[0] == 1'b0)
                    r = v + 1;
                while (!passes_trial_division(r))
                begin
                    if (r > mask - 2)
                    begin
                        ovf = 1'b1;
                        r   = 0;
                        break;
                    end
                    r += 2;
                end
            end
        end
        else if (req.action == ptns_pkg::ACT_PREV)
        begin
            if (v > 2)
            begin
                if (v[0] == 1'b0)
                    r = v - 1;
                while (!passes_trial_division(r))
                    r -= 2;
            end
        end
        res.prime_value = r[ptns_pkg::VALUE_W-1:0];
        res.prime_flag  = ovf ? 1'b0 : passes_trial_division(r);
        res.overflow    = ovf;
        return res;
    endfunction

    // Presents one request and returns at the edge that accepts it. The start
    // line is left high, so a following request goes out back to back.
    task automatic send_request(input logic [1:0] action,
                                input logic [ptns_pkg::VALUE_W-1:0] value);
        ptns_pkg::request_t req;
        ptns_pkg::result_t  want;
        req.action     = action;
        req.value      = value;
        division_tally = 0;
        want           = search_prime(req);
        cycle_limit   += 4 * (division_tally * DIV_CYCLES + 200);
        request <= req;
        start   <= 1'b1;
        // busy only moves on a rising edge, so the falling edge gives a clean
        // look at whether the next rising edge takes the request.
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        expected_results.push_back(want);
    endtask

    // Random idling on the request side. Most requests follow at once; some
    // wait a few cycles, some wait until the block has gone quiet so that a
    // request lands right as busy falls, and a few wait much longer.
    task automatic sender_idle();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return;
        start <= 1'b0;
        if (pick < 75)
            gap = $urandom_range(1, 3);
        else if (pick < 90)
        begin
            while (expected_results.size() != 0)
                @(negedge clk);
            @(posedge clk);
            gap = $urandom_range(0, 3);
        end
        else
            gap = $urandom_range(10, 60);
        cycle_limit += 4 * (gap + 10);
        repeat (gap) @(posedge clk);
    endtask

    // Waits with the start line low until every predicted result has come.
    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Primality tests on the small operands and on a few values that only the
    // 6k+-1 divisors or the division by 3 can catch. The spare action code
    // must behave like a test.
    task automatic test_small_operands();
        send_request(ACT_TEST, 0);
        send_request(ACT_TEST, 1);
        send_request(ACT_TEST, 2);
        send_request(ACT_TEST, 3);
        send_request(ACT_TEST, 4);
        send_request(ACT_TEST, 25);
        send_request(ACT_TEST, 49);
        send_request(ACT_TEST, 65521);
        send_request(ACT_SPARE, 7);
        send_request(ACT_SPARE, 9);
    endtask

    // The special cases of both searches, including successor overflow from
    // the top of the range and the value just below it.
    task automatic test_search_edges();
        send_request(ptns_pkg::ACT_NEXT, 0);
        send_request(ptns_pkg::ACT_PREV, 0);
        send_request(ptns_pkg::ACT_NEXT, 2);
        send_request(ptns_pkg::ACT_PREV, 2);
        send_request(ptns_pkg::ACT_PREV, 1);
        send_request(ptns_pkg::ACT_NEXT, 1);
        send_request(ptns_pkg::ACT_PREV, 3);
        send_request(ptns_pkg::ACT_NEXT, 24);
        send_request(ptns_pkg::ACT_PREV, 24);
        send_request(ptns_pkg::ACT_NEXT, 65522);
        send_request(ptns_pkg::ACT_NEXT, 32'hFFFF_FFFF);
        send_request(ptns_pkg::ACT_NEXT, 32'hFFFF_FFFE);
    endtask

    // Full-width operands that have a small factor, so each test ends early.
    task automatic test_wide_operands();
        send_request(ACT_TEST, 32'hFFFF_FFFF);
        send_request(ACT_TEST, 32'hFFFF_FFFE);
        send_request(ACT_TEST, 32'h8000_0000);
    endtask

    // Random requests. Searches stay on small and medium operands, where few
    // divisions are needed; full-width operands are tested only as
    // multiples of a small factor, which still toggles every bit of value.
    task automatic test_random_requests(input int count);
        logic [1:0]                  action;
        logic [ptns_pkg::VALUE_W-1:0] value;
        int                          shape;
        int unsigned                 factor;
        int unsigned                 multiple;
        int unsigned                 small_factors[6] = '{2, 3, 5, 7, 11, 13};
        repeat (count)
        begin
            action = 2'($urandom_range(0, 3));
            shape  = $urandom_range(0, 99);
            if (shape < 45)
                value = $urandom_range(0, 255);
            else if (shape < 75)
                value = $urandom_range(0, 65535);
            else if (shape < 82)
                value = $urandom_range(0, 1 << 18);
            else
            begin
                factor   = small_factors[$urandom_range(0, 5)];
                multiple = $urandom_range(0, 32'hFFFF_FFFF / factor);
                value    = ptns_pkg::VALUE_W'(factor * multiple);
                if (action == ptns_pkg::ACT_NEXT || action == ptns_pkg::ACT_PREV)
                    action = ACT_TEST;
            end
            send_request(action, value);
            sender_idle();
        end
    endtask

    // Result checker. The receiver cannot stall, so every strobe is a result
    // that must match the oldest prediction.
    always @(posedge clk)
    begin : check_results
        ptns_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result: prime_value=%0d prime_flag=%0b overflow=%0b",
                             result.prime_value, result.prime_flag, result.overflow);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.prime_value !== want.prime_value ||
                    result.prime_flag !== want.prime_flag ||
                    result.overflow !== want.overflow)
                begin
                    if (mismatch_count < MAX_REPORTS)
                    begin
                        $display("result mismatch: expected prime_value=%0d %s%0b overflow=%0b",
                                 want.prime_value, "prime_flag=", want.prime_flag,
                                 want.overflow);
                        $display("                 got prime_value=%0d %s%0b overflow=%0b",
                                 result.prime_value, "prime_flag=", result.prime_flag,
                                 result.overflow);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog. The limit grows with the predicted divider work of each
    // request and with each random idle gap of the sender.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit)
        begin
            $display("prime_test_and_neighbour_search_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_small_operands();
        test_search_edges();
        test_wide_operands();
        test_random_requests(40);
        // Let the block run dry once before the second random batch.
        drain_results();
        test_random_requests(40);

        drain_results();
        // A few divisions' worth of extra cycles catch any stray strobe.
        repeat (4 * DIV_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("prime_test_and_neighbour_search_test OK");
        else
            $display("prime_test_and_neighbour_search_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
sv/ptns_pkg.sv
sv/ptns_div.sv
sv/ptns_dp.sv
sv/ptns_ctrl.sv
sv/prime_test_and_neighbour_search.sv
tb/prime_test_and_neighbour_search_test.sv
